// ----- sv/serial_line_assembler_fastpath_macros.svh -----
// Assertion helpers used by the top-level RTL; clock is aclk, reset is aresetn.
`ifndef SERIAL_LINE_ASSEMBLER_FASTPATH_MACROS_SVH
`define SERIAL_LINE_ASSEMBLER_FASTPATH_MACROS_SVH

// Consequent must hold in the same cycle.
`define SLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the following cycle.
`define SLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sla_pkg.sv -----
package sla_pkg;

    // Wide enough for a line length up to the largest supported cap (64).
    localparam int LEN_W = 7;

    // Line classification; the first three double as the result action code.
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_ON   = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [16:0] FREQ_MAX = 17'h0FFFF;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] len;
        logic [15:0]      freq;
        logic             bank;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic             bank;
        logic [LEN_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

endpackage

// ----- sv/sla_fifo.sv -----
module sla_fifo
    import sla_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t din,
    input  logic pop,
    output logic full,
    output logic valid,
    output cmd_t dout
);

    cmd_t       ent_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = ent_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- sv/sla_front.sv -----
module sla_front
    import sla_pkg::*;
#(
    parameter int LINE_CAP = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       q_full,
    input  rel_t       rel,
    output logic       push,
    output cmd_t       cmd,
    output wr_t        wr
);

    localparam int CW = $clog2(LINE_CAP + 1);

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_DIG  = 3'd2;
    localparam logic [2:0] PH_END  = 3'd3;
    localparam logic [2:0] PH_BAD  = 3'd4;

    logic [CW-1:0] count_reg, count_next;
    logic          bank_reg, bank_next;
    logic [1:0]    busy_reg, busy_next;
    logic [2:0]    phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic          over_reg, over_next;
    logic [16:0]   val_reg, val_next;
    logic          pf_ok_reg, pf_ok_next;
    logic          pn_ok_reg, pn_ok_next;

    logic          accept, is_term, store, is_digit, is_blank;
    logic [20:0]   acc;
    logic [1:0]    kind;

    assign s_tready = !q_full && !busy_reg[bank_reg];
    assign accept   = s_tvalid && s_tready;
    assign is_term  = (s_tdata == CH_LF) || (s_tdata == CH_CR);
    assign store    = accept && !is_term && (count_reg < CW'(LINE_CAP));
    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB) ||
                      (s_tdata == CH_VT) || (s_tdata == CH_FF);
    // val*10 + digit as shift-add
    assign acc = {1'b0, val_reg, 3'b000} + {3'b000, val_reg, 1'b0} +
                 {17'd0, s_tdata[3:0]};

    always_comb begin
        kind = KIND_LINE;
        if (count_reg == CW'(3) && pf_ok_reg) begin
            kind = KIND_OFF;
        end else if (count_reg > CW'(4) && pn_ok_reg) begin
            if ((phase_reg == PH_DIG || phase_reg == PH_END) && !over_reg &&
                !(neg_reg && val_reg != 17'd0)) begin
                kind = KIND_ON;
            end else begin
                kind = KIND_DROP;
            end
        end
    end

    assign push     = accept && is_term && (count_reg != '0) && (kind != KIND_DROP);
    assign cmd.kind = kind;
    assign cmd.len  = LEN_W'(count_reg);
    assign cmd.freq = (kind == KIND_ON) ? val_reg[15:0] : 16'd0;
    assign cmd.bank = bank_reg;

    assign wr.en   = store;
    assign wr.bank = bank_reg;
    assign wr.addr = LEN_W'(count_reg);
    assign wr.data = s_tdata;

    always_comb begin
        count_next = count_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        over_next  = over_reg;
        val_next   = val_reg;
        pf_ok_next = pf_ok_reg;
        pn_ok_next = pn_ok_reg;

        if (rel.en) begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept && is_term) begin
            count_next = '0;
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            over_next  = 1'b0;
            val_next   = 17'd0;
            if (push && kind == KIND_LINE) begin
                busy_next[bank_reg] = 1'b1;
                bank_next           = !bank_reg;
            end
        end else if (store) begin
            count_next = count_reg + CW'(1);
            case (count_reg)
                CW'(0): begin
                    pf_ok_next = (s_tdata == CH_SLASH);
                    pn_ok_next = (s_tdata == CH_SLASH);
                end
                CW'(1): begin
                    pf_ok_next = pf_ok_reg && (s_tdata == CH_P);
                    pn_ok_next = pn_ok_reg && (s_tdata == CH_P);
                end
                CW'(2): begin
                    pf_ok_next = pf_ok_reg && (s_tdata == CH_F);
                    pn_ok_next = pn_ok_reg && (s_tdata == CH_N);
                end
                CW'(3): begin
                    pn_ok_next = pn_ok_reg && (s_tdata == CH_MINUS);
                end
                default: begin
                    // number text after the note-on prefix
                    case (phase_reg)
                        PH_LEAD: begin
                            if (is_blank) begin
                                phase_next = PH_LEAD;
                            end else if (s_tdata == CH_PLUS || s_tdata == CH_MINUS) begin
                                neg_next   = (s_tdata == CH_MINUS);
                                phase_next = PH_SIGN;
                            end else if (is_digit) begin
                                phase_next = PH_DIG;
                            end else begin
                                phase_next = PH_BAD;
                            end
                        end
                        PH_SIGN: begin
                            phase_next = is_digit ? PH_DIG : PH_BAD;
                        end
                        PH_DIG: begin
                            if (is_digit) begin
                                phase_next = PH_DIG;
                            end else if (s_tdata == CH_NUL) begin
                                phase_next = PH_END;
                            end else begin
                                phase_next = PH_BAD;
                            end
                        end
                        PH_END: phase_next = PH_END;
                        default: phase_next = PH_BAD;
                    endcase
                    if (is_digit && (phase_reg == PH_LEAD || phase_reg == PH_SIGN ||
                                     phase_reg == PH_DIG)) begin
                        if (acc > {4'd0, FREQ_MAX}) begin
                            over_next = 1'b1;
                            val_next  = FREQ_MAX + 17'd1;
                        end else begin
                            val_next = acc[16:0];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        pf_ok_reg <= pf_ok_next;
        pn_ok_reg <= pn_ok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
            busy_reg  <= 2'b00;
            phase_reg <= PH_LEAD;
            over_reg  <= 1'b0;
            val_reg   <= 17'd0;
            neg_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            over_reg  <= over_next;
            val_reg   <= val_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

// ----- sv/sla_back.sv -----
module sla_back
    import sla_pkg::*;
#(
    parameter int LINE_CAP = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  wr_t         wr,
    input  logic        head_valid,
    input  cmd_t        head,
    output logic        pop,
    output rel_t        rel,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int AW    = $clog2(LINE_CAP);
    localparam int DEPTH = 2 * (1 << AW);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_action_reg;
    logic [7:0]       out_char_reg;
    logic             out_bank_reg;
    logic [5:0]       out_len_reg;
    logic [15:0]      out_freq_reg;
    logic             out_last_reg;

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             rd_pending_reg;
    logic             pend_bank_reg;
    logic [5:0]       pend_len_reg;
    logic             pend_last_reg;

    logic             out_free, go, fast, issue, last_char;

    assign out_free  = !out_valid_reg || m_tready;
    assign go        = head_valid && out_free && !rd_pending_reg;
    assign fast      = (head.kind != KIND_LINE);
    assign issue     = go && !fast;
    assign last_char = ((idx_reg + LEN_W'(1)) == head.len);
    assign pop       = go && (fast || last_char);
    assign rel.en    = issue && last_char;
    assign rel.bank  = head.bank;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_freq_reg, out_len_reg, out_bank_reg, out_char_reg};

    always_comb begin
        idx_next = idx_reg;
        if (issue) begin
            idx_next = last_char ? '0 : idx_reg + LEN_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (rd_pending_reg || (go && fast)) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[{wr.bank, wr.addr[AW-1:0]}] <= wr.data;
        end
        if (issue) begin
            rd_data_reg <= mem[{head.bank, idx_reg[AW-1:0]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_bank_reg <= head.bank;
            pend_len_reg  <= head.len[5:0];
            pend_last_reg <= last_char;
        end
        if (rd_pending_reg) begin
            out_action_reg <= KIND_LINE;
            out_char_reg   <= rd_data_reg;
            out_bank_reg   <= pend_bank_reg;
            out_len_reg    <= pend_len_reg;
            out_freq_reg   <= 16'd0;
            out_last_reg   <= pend_last_reg;
        end else if (go && fast) begin
            out_action_reg <= head.kind;
            out_char_reg   <= 8'd0;
            out_bank_reg   <= head.bank;
            out_len_reg    <= head.len[5:0];
            out_freq_reg   <= head.freq;
            out_last_reg   <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            rd_pending_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            rd_pending_reg <= issue;
        end
    end

endmodule

// ----- sv/serial_line_assembler_fastpath.sv -----
// Serial line assembler with a note-off / note-on fast path.
// Input: s_tvalid/s_tready/s_tdata carry one received byte per transaction.
// Output: m_tvalid/m_tready with m_tdata (char, bank, length, frequency),
// m_tuser (action) and m_tlast marking the final result of a closed line.
// Data bytes are stored in a two-bank line buffer, one per cycle while
// s_tready is high. A CR or LF closes the line; the parse is done on the
// fly, so the close is classified in the same cycle and a command, unless
// the line is empty or dropped, enters a two-entry queue. The back end
// turns a command into results: a fast-path command gives one result; an
// ordinary line streams its characters one at a time, each read from the
// buffer into a read register and then moved to the output register before
// the next read is issued. A byte is refused while the queue is full or
// while the bank being filled still has a line waiting to stream, so a
// stalled receiver backs up into the input after at most two queued lines.
// Reset clears the line count, bank, busy flags, queue pointers and output
// valid flag; the buffer contents are not cleared and need no clearing pass.
`include "serial_line_assembler_fastpath_macros.svh"

module serial_line_assembler_fastpath
    import sla_pkg::*;
#(
    parameter int LINE_CAP = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] char_out, [8] bank, [14:9] line_length,
                                   // [30:15] frequency, [31] zero
    output logic [1:0]  m_tuser,   // [1:0] action
    output logic        m_tlast
);

    logic q_full, q_valid, q_push, q_pop;
    cmd_t q_din, q_head;
    wr_t  wr;
    rel_t rel;

    sla_front #(.LINE_CAP(LINE_CAP)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .rel      (rel),
        .push     (q_push),
        .cmd      (q_din),
        .wr       (wr)
    );

    sla_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .full    (q_full),
        .valid   (q_valid),
        .dout    (q_head)
    );

    sla_back #(.LINE_CAP(LINE_CAP)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .rel        (rel),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    `SLA_ASSERT_NOW(a_no_push_full, q_push, !q_full, "command pushed into full queue")
    `SLA_ASSERT_NOW(a_fast_clean, m_tvalid && m_tuser != KIND_LINE, m_tlast && m_tdata[7:0] == 8'd0, "fast-path result not single or has char")
    `SLA_ASSERT_NOW(a_len_nonzero, m_tvalid, m_tdata[14:9] != 6'd0 || LINE_CAP >= 64, "result with zero line length")
    `SLA_ASSERT_NEXT(a_fast_out, q_pop && q_head.kind != KIND_LINE, m_tvalid && m_tlast, "fast-path command produced no result")

endmodule

// ----- bench/serial_line_assembler_fastpath_test.sv -----
`timescale 1ns / 1ps

module serial_line_assembler_fastpath_test
    import sla_pkg::*;
();

    localparam int LINE_CAP     = 32;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  ch;
        logic        bank;
        logic [5:0]  len;
        logic [15:0] freq;
        logic        last;
    } line_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    logic [7:0]   line_chars [LINE_CAP];
    int unsigned  held;
    logic         cur_bank;
    line_result_t pending_results [$];
    line_result_t want;

    logic [7:0]   line_text [$];
    int unsigned  bytes_taken;
    int unsigned  errors;
    int unsigned  cycle_count;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  hold_len;
    int unsigned  hold_left;
    bit           hold_req;

    serial_line_assembler_fastpath #(
        .LINE_CAP(LINE_CAP)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_line_assembler_fastpath test failed");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, exp_v);
        errors++;
    endtask

    // Returns KIND_LINE, KIND_OFF, KIND_ON or KIND_DROP for the held line.
    function automatic logic [1:0] classify_line(input int unsigned n,
                                                 output logic [15:0] freq);
        int unsigned i;
        int unsigned first;
        int unsigned val;
        bit neg;
        bit over;
        freq = '0;
        neg = 1'b0;
        over = 1'b0;
        val = 0;
        if (n == 3 && line_chars[0] == CH_SLASH && line_chars[1] == CH_P &&
            line_chars[2] == CH_F)
            return KIND_OFF;
        if (!(n > 4 && line_chars[0] == CH_SLASH && line_chars[1] == CH_P &&
              line_chars[2] == CH_N && line_chars[3] == CH_MINUS))
            return KIND_LINE;
        i = 4;
        while (i < n && (line_chars[i] == CH_SPACE || line_chars[i] == CH_TAB ||
                         line_chars[i] == CH_VT || line_chars[i] == CH_FF))
            i++;
        if (i < n && (line_chars[i] == CH_PLUS || line_chars[i] == CH_MINUS)) begin
            neg = (line_chars[i] == CH_MINUS);
            i++;
        end
        first = i;
        while (i < n && line_chars[i] >= CH_ZERO && line_chars[i] <= CH_NINE) begin
            val = val * 10 + 32'(line_chars[i] - CH_ZERO);
            // saturate so long digit runs cannot wrap
            if (val > FREQ_MAX) begin
                over = 1'b1;
                val = FREQ_MAX + 1;
            end
            i++;
        end
        if (i == first)
            return KIND_DROP;
        if (i < n && line_chars[i] != CH_NUL)
            return KIND_DROP;
        if (over || (neg && val != 0))
            return KIND_DROP;
        freq = val[15:0];
        return KIND_ON;
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        logic [1:0]   kind;
        logic [15:0]  freq;
        line_result_t r;
        int unsigned  k;
        if (b == CH_LF || b == CH_CR) begin
            if (held > 0) begin
                kind = classify_line(held, freq);
                r.action = kind;
                r.ch = '0;
                r.bank = cur_bank;
                r.len = held[5:0];
                r.freq = freq;
                r.last = 1'b1;
                if (kind == KIND_OFF || kind == KIND_ON) begin
                    pending_results.push_back(r);
                end else if (kind == KIND_LINE) begin
                    for (k = 0; k < held; k++) begin
                        r.ch = line_chars[k];
                        r.last = (k + 1 == held);
                        pending_results.push_back(r);
                    end
                    cur_bank = ~cur_bank;
                end
                held = 0;
            end
        end else if (held < LINE_CAP) begin
            line_chars[held] = b;
            held++;
        end
    endfunction

    // One byte per transaction; valid stays high across back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_taken++;
        track_byte(b);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_text.push_back(s[i]);
    endtask

    task automatic send_line(input logic [7:0] term);
        while (line_text.size() > 0)
            send_byte(line_text.pop_front());
        send_byte(term);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic build_note_on();
        int unsigned v;
        int unsigned sign_pick;
        int unsigned n;
        int unsigned i;
        push_text("/pn-");
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(3, 1);
            for (i = 0; i < n; i++)
                line_text.push_back(blank_byte());
        end
        sign_pick = $urandom_range(99);
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(999);
            4, 5:       v = $urandom_range(65535);
            6:          v = 65535;
            7:          v = $urandom_range(99999, 65536);
            default:    v = 0;
        endcase
        if (sign_pick < 15) begin
            line_text.push_back(CH_PLUS);
        end else if (sign_pick < 30) begin
            line_text.push_back(CH_MINUS);
            if ($urandom_range(9) < 7)
                v = 0;
        end
        if ($urandom_range(4) == 0) begin
            n = $urandom_range(2, 1);
            for (i = 0; i < n; i++)
                line_text.push_back(CH_ZERO);
        end
        if ($urandom_range(19) != 0)
            push_text($sformatf("%0d", v));
        case ($urandom_range(7))
            0: begin
                line_text.push_back(CH_NUL);
                n = $urandom_range(3);
                for (i = 0; i < n; i++)
                    line_text.push_back(text_byte());
            end
            1: line_text.push_back(text_byte());
            default: ;
        endcase
    endtask

    task automatic send_random_line();
        int unsigned sel;
        int unsigned n;
        int unsigned i;
        sel = $urandom_range(99);
        if (sel < 12) begin
            case ($urandom_range(5))
                0: push_text("/p");
                1: push_text("/pn-");
                2: begin
                    push_text("/pf");
                    line_text.push_back(text_byte());
                end
                default: push_text("/pf");
            endcase
        end else if (sel < 45) begin
            build_note_on();
        end else if (sel < 82) begin
            n = ($urandom_range(7) == 0) ? $urandom_range(40, 28) : $urandom_range(12, 1);
            for (i = 0; i < n; i++)
                line_text.push_back(text_byte());
        end else begin
            // noise: terminators may land anywhere, including on empty lines
            n = $urandom_range(8);
            for (i = 0; i < n; i++)
                line_text.push_back(8'($urandom_range(255)));
        end
        send_line($urandom_range(1) ? CH_CR : CH_LF);
    endtask

    task automatic test_empty_line();
        send_line(CH_LF);
    endtask

    task automatic test_note_off();
        push_text("/pf");
        send_line(CH_CR);
    endtask

    task automatic test_note_on_max();
        push_text("/pn-65535");
        send_line(CH_LF);
    endtask

    task automatic test_minus_zero();
        push_text("/pn--0");
        send_line(CH_CR);
    endtask

    task automatic test_short_prefix();
        push_text("/pn-");
        send_line(CH_LF);
    endtask

    task automatic test_extreme_bytes();
        line_text.push_back(CH_NUL);
        line_text.push_back(8'hFF);
        send_line(CH_CR);
    endtask

    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned budget);
        int unsigned target;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        target = bytes_taken + budget;
        while (bytes_taken < target)
            send_random_line();
    endtask

    // Receiver holds off while 20-character lines keep arriving.
    task automatic test_backpressure();
        int unsigned n;
        int unsigned i;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 400;
        hold_req = 1'b1;
        for (n = 0; n < 4; n++) begin
            for (i = 0; i < 20; i++)
                line_text.push_back(text_byte());
            send_line(CH_LF);
        end
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = hold_len;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report("unexpected transaction", m_tdata, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.action)
                    report("action", 32'(m_tuser), 32'(want.action));
                if (m_tdata[7:0] !== want.ch)
                    report("char_out", 32'(m_tdata[7:0]), 32'(want.ch));
                if (m_tdata[8] !== want.bank)
                    report("bank", 32'(m_tdata[8]), 32'(want.bank));
                if (m_tdata[14:9] !== want.len)
                    report("line_length", 32'(m_tdata[14:9]), 32'(want.len));
                if (m_tdata[30:15] !== want.freq)
                    report("frequency", 32'(m_tdata[30:15]), 32'(want.freq));
                if (m_tlast !== want.last)
                    report("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        held = 0;
        cur_bank = 1'b0;
        bytes_taken = 0;
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 0;
        hold_left = 0;
        hold_req = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_line();
        test_note_off();
        test_note_on_max();
        test_minus_zero();
        test_short_prefix();
        test_extreme_bytes();

        test_random_traffic(0, 0, 75);
        test_random_traffic(83, 0, 75);
        test_random_traffic(0, 83, 75);
        test_random_traffic(29, 29, 75);
        test_backpressure();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("serial_line_assembler_fastpath test passed");
        else
            $display("serial_line_assembler_fastpath test failed");
        $finish;
    end

endmodule

// ----- serial_line_assembler_fastpath.f -----
+incdir+sv
sv/sla_pkg.sv
sv/sla_fifo.sv
sv/sla_front.sv
sv/sla_back.sv
sv/serial_line_assembler_fastpath.sv
bench/serial_line_assembler_fastpath_test.sv
